@@ hw/rtl/kdb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, codes and defaults of the key debounce block.
package kdb_pkg;

  localparam int KEY_W      = 4;
  localparam int EVENT_W    = 2;
  localparam int DEB_W      = 8;
  localparam int LONG_W     = 10;
  localparam int REP_W      = 8;
  localparam int HOLD_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int NUM_KEYS_DEFAULT = 12;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd4;
  localparam logic [LONG_W-1:0] LONG_RESET     = 10'd150;
  localparam logic [REP_W-1:0]  REPEAT_RESET   = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } kdb_event_t;

  typedef struct packed {
    logic              stable;
    logic              prev;
    logic [DEB_W-1:0]  deb;
    logic [HOLD_W-1:0] hold;
    logic [REP_W-1:0]  rep;
  } kdb_state_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [LONG_W-1:0] long_press_ticks;
    logic [REP_W-1:0]  repeat_ticks;
  } kdb_cfg_t;

  localparam kdb_state_t STATE_RESET = '{
    stable: 1'b1,
    prev:   1'b1,
    deb:    '0,
    hold:   '0,
    rep:    '0
  };

endpackage

@@ hw/rtl/kdb_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for poll ticks and key events.
interface kdb_in_if;
  logic                       valid;
  logic                       ready;
  logic [kdb_pkg::KEY_W-1:0]  key_index;
  logic                       level;

  modport source (output valid, key_index, level, input ready);
  modport sink   (input valid, key_index, level, output ready);
endinterface

interface kdb_out_if;
  logic                        valid;
  logic                        ready;
  logic [kdb_pkg::KEY_W-1:0]   key_id;
  logic [kdb_pkg::EVENT_W-1:0] event_res;

  modport source (output valid, key_id, event_res, input ready);
  modport sink   (input valid, key_id, event_res, output ready);
endinterface

@@ hw/rtl/kdb_update.sv @@
`timescale 1ns / 1ps
// Per-key next-state and event logic for one poll tick.
module kdb_update (
  input  kdb_pkg::kdb_state_t cur,
  input  logic                level,
  input  kdb_pkg::kdb_cfg_t   cfg,
  output kdb_pkg::kdb_state_t nxt,
  output kdb_pkg::kdb_event_t ev
);

  always_comb begin
    logic [kdb_pkg::HOLD_W-1:0] long_ext;
    long_ext = {1'b0, cfg.long_press_ticks};
    nxt = cur;
    ev  = kdb_pkg::EV_NONE;

    if (level != cur.prev) begin
      nxt.deb = '0;
    end else if (cur.deb < cfg.debounce_ticks) begin
      nxt.deb = cur.deb + 8'd1;
    end else if (level != cur.stable) begin
      nxt.stable = level;
      if (level && (cur.hold < long_ext)) begin
        ev = kdb_pkg::EV_SHORT;
      end
      nxt.hold = '0;
    end
    nxt.prev = level;

    if (!nxt.stable) begin
      if (nxt.hold <= long_ext) begin
        nxt.hold = nxt.hold + 11'd1;
      end
      if (nxt.hold == long_ext) begin
        ev = kdb_pkg::EV_LONG;
      end
      if (nxt.hold > long_ext) begin
        nxt.rep = cur.rep + 8'd1;
        if (nxt.rep >= cfg.repeat_ticks) begin
          nxt.rep = '0;
          ev = kdb_pkg::EV_LONG;
        end
      end
    end
  end

endmodule

@@ hw/rtl/key_debounce_long_press_repeat.sv @@
`timescale 1ns / 1ps
// A poll word is held in s1, its result in the output register. Throughput: one
// poll word per cycle while event_out is not stalled; the per-key state memory is
// read on accept, written back as the word leaves s1, with write data forwarded
// to a same-key read. Reset: config returns to defaults; per-key valid bits clear
// at once, so every key reads as released with zero counters. No clearing pass.
module key_debounce_long_press_repeat #(
  parameter int NUM_KEYS = kdb_pkg::NUM_KEYS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  kdb_in_if.sink                              key_in,
  kdb_out_if.source                           event_out,
  input  logic                                cfg_we,
  input  logic [kdb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kdb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kdb_pkg::kdb_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= kdb_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks <= kdb_pkg::LONG_RESET;
      cfg.repeat_ticks     <= kdb_pkg::REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kdb_pkg::CFG_DEBOUNCE: cfg.debounce_ticks   <= cfg_data[kdb_pkg::DEB_W-1:0];
        kdb_pkg::CFG_LONG:     cfg.long_press_ticks <= cfg_data[kdb_pkg::LONG_W-1:0];
        kdb_pkg::CFG_REPEAT:   cfg.repeat_ticks     <= cfg_data[kdb_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  logic                       accept;
  logic                       in_range;
  logic [IDX_W-1:0]           rd_addr;
  logic                       s1_valid;
  logic [kdb_pkg::KEY_W-1:0]  s1_key;
  logic                       s1_level;
  logic                       s1_in_range;
  logic [IDX_W-1:0]           s1_addr;
  logic                       s1_adv;
  logic                       out_valid;
  logic [kdb_pkg::KEY_W-1:0]  out_key;
  kdb_pkg::kdb_event_t        out_event;

  assign s1_adv       = !out_valid || event_out.ready;
  assign key_in.ready = !s1_valid || s1_adv;
  assign accept       = key_in.valid && key_in.ready;
  assign in_range     = 32'(key_in.key_index) < NUM_KEYS;
  assign rd_addr      = in_range ? IDX_W'(key_in.key_index) : '0;

  // State memory with per-key valid bits and same-key forwarding
  kdb_pkg::kdb_state_t mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld;
  kdb_pkg::kdb_state_t rd_data;
  logic                rd_vld;
  logic                fwd_hit;
  kdb_pkg::kdb_state_t fwd_data;
  logic                wr_en;
  kdb_pkg::kdb_state_t wr_data;
  kdb_pkg::kdb_state_t cur;
  kdb_pkg::kdb_event_t upd_event;

  assign wr_en = s1_valid && s1_adv && s1_in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
    if (accept) begin
      rd_data  <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[s1_addr] <= 1'b1;
      end
      if (accept) begin
        rd_vld  <= vld[rd_addr];
        fwd_hit <= wr_en && (s1_addr == rd_addr);
      end
    end
  end

  assign cur = fwd_hit ? fwd_data : (rd_vld ? rd_data : kdb_pkg::STATE_RESET);

  kdb_update u_update (
    .cur   (cur),
    .level (s1_level),
    .cfg   (cfg),
    .nxt   (wr_data),
    .ev    (upd_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key      <= key_in.key_index;
      s1_level    <= key_in.level;
      s1_in_range <= in_range;
      s1_addr     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_key   <= s1_key;
      out_event <= s1_in_range ? upd_event : kdb_pkg::EV_NONE;
    end
  end

  assign event_out.valid     = out_valid;
  assign event_out.key_id    = out_key;
  assign event_out.event_res = out_event;

  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    (wr_en && accept && (s1_addr == rd_addr)) |=> fwd_hit)
    else $error("same-key write not forwarded");

  a_write_legal: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && s1_in_range))
    else $error("state write without an in-range word");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_event == kdb_pkg::EV_NONE || out_event == kdb_pkg::EV_SHORT ||
                   out_event == kdb_pkg::EV_LONG))
    else $error("illegal event code");

  a_range_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (32'(out_key) >= NUM_KEYS)) |-> (out_event == kdb_pkg::EV_NONE))
    else $error("event on out-of-range key");

  a_vld_cleared: assert property (@(posedge clk)
    $fell(rst) |-> (vld == '0))
    else $error("valid bits not cleared by reset");

endmodule

@@ tb/sv/kdb_event_checker.sv @@
`timescale 1ns / 1ps
// Event checker: predicts each key event from the poll words and compares it with the block.
module kdb_event_checker #(
  parameter int NUM_KEYS = kdb_pkg::NUM_KEYS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  kdb_in_if                              key_in,
  kdb_out_if                             event_out,
  input  logic                           cfg_we,
  input  logic [kdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             open_events,
  output int                             mismatches
);

  typedef struct packed {
    logic [kdb_pkg::KEY_W-1:0] key_id;
    kdb_pkg::kdb_event_t       ev;
  } key_event_t;

  kdb_pkg::kdb_state_t key_state [NUM_KEYS];
  kdb_pkg::kdb_cfg_t   cfg_shadow;
  key_event_t          due_events [$];

  function automatic kdb_pkg::kdb_event_t qualify_tick(input logic [kdb_pkg::KEY_W-1:0] k,
                                                       input logic lv);
    kdb_pkg::kdb_state_t         st;
    kdb_pkg::kdb_event_t         ev;
    logic [kdb_pkg::HOLD_W-1:0]  long_ext;
    ev = kdb_pkg::EV_NONE;
    if (32'(k) >= NUM_KEYS) return kdb_pkg::EV_NONE;
    long_ext = {1'b0, cfg_shadow.long_press_ticks};
    st = key_state[k];
    if (lv != st.prev) begin
      st.deb = '0;
    end else if (st.deb < cfg_shadow.debounce_ticks) begin
      st.deb = st.deb + 8'd1;
    end else if (lv != st.stable) begin
      st.stable = lv;
      if (!lv) begin
        st.hold = '0;
      end else begin
        if (st.hold < long_ext) ev = kdb_pkg::EV_SHORT;
        st.hold = '0;
      end
    end
    st.prev = lv;
    if (!st.stable) begin
      if (st.hold <= long_ext) st.hold = st.hold + 11'd1;
      if (st.hold == long_ext) ev = kdb_pkg::EV_LONG;
      if (st.hold > long_ext) begin
        st.rep = st.rep + 8'd1;
        if (st.rep >= cfg_shadow.repeat_ticks) begin
          st.rep = '0;
          ev = kdb_pkg::EV_LONG;
        end
      end
    end
    key_state[k] = st;
    return ev;
  endfunction

  always @(posedge clk) begin
    key_event_t fresh;
    key_event_t want;
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) key_state[k] = kdb_pkg::STATE_RESET;
      cfg_shadow = '{kdb_pkg::DEBOUNCE_RESET, kdb_pkg::LONG_RESET, kdb_pkg::REPEAT_RESET};
      due_events.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kdb_pkg::CFG_DEBOUNCE:
            cfg_shadow.debounce_ticks = cfg_data[kdb_pkg::DEB_W-1:0];
          kdb_pkg::CFG_LONG:
            cfg_shadow.long_press_ticks = cfg_data[kdb_pkg::LONG_W-1:0];
          kdb_pkg::CFG_REPEAT:
            cfg_shadow.repeat_ticks = cfg_data[kdb_pkg::REP_W-1:0];
          default: ;
        endcase
      end
      if (key_in.valid && key_in.ready) begin
        fresh.key_id = key_in.key_index;
        fresh.ev = qualify_tick(key_in.key_index, key_in.level);
        due_events.push_back(fresh);
      end
      if (event_out.valid && event_out.ready) begin
        if (due_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected event word, expected none, actual key_id %0d event_res %0d",
                   $time, event_out.key_id, event_out.event_res);
        end else begin
          want = due_events.pop_front();
          if (event_out.key_id !== want.key_id) begin
            mismatches++;
            $display("%0t: key_id mismatch, expected %0d, actual %0d",
                     $time, want.key_id, event_out.key_id);
          end
          if (event_out.event_res !== want.ev) begin
            mismatches++;
            $display("%0t: event_res mismatch on key %0d, expected %0d, actual %0d",
                     $time, want.key_id, want.ev, event_out.event_res);
          end
        end
      end
    end
    open_events = due_events.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives poll words and config writes into the key debouncer and gives the verdict.
module tb_top;

  localparam int NUM_KEYS   = kdb_pkg::NUM_KEYS_DEFAULT;
  localparam int LIMIT      = 1500000;
  localparam int LONG_STALL = 300;
  localparam logic [kdb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [kdb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kdb_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             open_events;
  int                             mismatches;
  int                             cycle_count;

  bit quiet;
  int stall_reqs;
  int stalls_done;
  int deb_now;
  int long_now;
  int rep_now;
  int   plan_left [16];
  logic plan_lvl  [16];

  kdb_in_if  poll_ch ();
  kdb_out_if event_ch ();

  key_debounce_long_press_repeat #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk       (clk),
    .rst       (rst),
    .key_in    (poll_ch),
    .event_out (event_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kdb_event_checker #(.NUM_KEYS(NUM_KEYS)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .key_in      (poll_ch),
    .event_out   (event_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .open_events (open_events),
    .mismatches  (mismatches)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_poll(input logic [kdb_pkg::KEY_W-1:0] k, input logic lv);
    int gap;
    gap = (quiet || $urandom_range(0, 1)) ? 0 : idle_cycles();
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid     <= 1'b1;
    poll_ch.key_index <= k;
    poll_ch.level     <= lv;
    do @(posedge clk); while (!poll_ch.ready);
  endtask

  task automatic hold_level(input int k, input logic lv, input int n);
    repeat (n) send_poll(k[kdb_pkg::KEY_W-1:0], lv);
  endtask

  // hold off until the block has returned every event
  task automatic drain();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    wait (open_events == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int d, input int l, input int r);
    logic [1:0] pad;
    pad = 2'($urandom_range(0, 3));
    cfg_we    <= 1'b1;
    cfg_index <= kdb_pkg::CFG_DEBOUNCE;
    cfg_data  <= {pad, d[7:0]};
    @(posedge clk);
    cfg_index <= kdb_pkg::CFG_LONG;
    cfg_data  <= l[9:0];
    @(posedge clk);
    pad = 2'($urandom_range(0, 3));
    cfg_index <= kdb_pkg::CFG_REPEAT;
    cfg_data  <= {pad, r[7:0]};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 10'($urandom_range(0, 1023));
    @(posedge clk);
    cfg_we <= 1'b0;
    deb_now  = d;
    long_now = l;
    rep_now  = r;
  endtask

  // per-key press/release plans with bounce noise and stray key indexes
  task automatic run_random(input int nkeys, input int count, input int stall_at);
    int k;
    int r;
    logic lv;
    for (int i = 0; i < count; i++) begin
      if (i == stall_at) stall_reqs++;
      if ($urandom_range(0, 99) < 3) begin
        send_poll(4'($urandom_range(NUM_KEYS, 15)), 1'($urandom_range(0, 1)));
      end else begin
        k = $urandom_range(0, nkeys - 1);
        if (plan_left[k] == 0) begin
          plan_lvl[k] = ~plan_lvl[k];
          r = $urandom_range(0, 99);
          if (r < 15) begin
            plan_left[k] = $urandom_range(1, deb_now + 2);
          end else if (r < 50) begin
            plan_left[k] = deb_now + 1 + $urandom_range(0, long_now);
          end else begin
            plan_left[k] = deb_now + 1 + long_now + $urandom_range(0, 3 * rep_now + 4);
          end
        end
        lv = plan_lvl[k];
        if ($urandom_range(0, 99) < 4) lv = ~lv;
        plan_left[k]--;
        send_poll(k[kdb_pkg::KEY_W-1:0], lv);
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    event_ch.ready <= 1'b0;
    forever begin
      if (stalls_done != stall_reqs) begin
        event_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stalls_done++;
      end else if (quiet) begin
        event_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        event_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        event_ch.ready <= 1'b0;
        repeat (idle_cycles()) @(posedge clk);
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= kdb_pkg::CFG_DEBOUNCE;
    cfg_data          <= '0;
    poll_ch.valid     <= 1'b0;
    poll_ch.key_index <= '0;
    poll_ch.level     <= 1'b1;
    quiet       = 1'b0;
    stall_reqs  = 0;
    stalls_done = 0;
    deb_now  = kdb_pkg::DEBOUNCE_RESET;
    long_now = kdb_pkg::LONG_RESET;
    rep_now  = kdb_pkg::REPEAT_RESET;
    for (int k = 0; k < 16; k++) begin
      plan_left[k] = 0;
      plan_lvl[k]  = 1'b1;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_poll(4'(NUM_KEYS), 1'b0);
    send_poll(4'd15, 1'b1);
    hold_level(0, 1'b0, 6);
    hold_level(0, 1'b1, 6);
    send_poll(4'd11, 1'b0);
    send_poll(4'd11, 1'b1);
    send_poll(4'd11, 1'b0);
    send_poll(4'd11, 1'b1);
    hold_level(7, 1'b1, 2);
    run_random(2, 100, -1);
    drain();

    set_config(0, 0, 0);
    hold_level(5, 1'b0, 4);
    hold_level(5, 1'b1, 2);
    run_random(NUM_KEYS, 50, -1);
    drain();

    quiet = 1'b1;
    set_config(1, 3, 1);
    run_random(NUM_KEYS, 60, -1);
    drain();
    quiet = 1'b0;

    set_config(2, 8, 3);
    run_random(NUM_KEYS, 100, 40);
    drain();

    set_config(255, 1, 1);
    hold_level(3, 1'b0, 300);
    hold_level(3, 1'b1, 257);
    drain();

    set_config(0, 1023, 255);
    hold_level(11, 1'b0, 1300);
    hold_level(11, 1'b1, 2);
    hold_level(11, 1'b0, 10);
    hold_level(11, 1'b1, 2);
    drain();

    set_config(3, 20, 5);
    run_random(NUM_KEYS, 60, -1);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
